/* hw/rtl/plau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projectile launch angle: shared package
// Widths, reset values, register and status codes and the arctangent table
// used by the launch angle pipeline and its cells.
// ----------------------------------------------------------------------------
package plau_pkg;

    // Pipeline sizing
    localparam int CORDIC_STAGES_DEF = 24;
    localparam int CORDIC_MAX        = 32;

    // Field and datapath widths
    localparam int V_W        = 23;   // launch speed register
    localparam int G_W        = 22;   // gravity register
    localparam int P_W        = 32;   // one coordinate
    localparam int D_W        = 33;   // coordinate difference and its magnitude
    localparam int Q_W        = 66;   // squared horizontal distance
    localparam int V2_W       = 46;   // speed squared
    localparam int G2_W       = 44;   // gravity squared
    localparam int V4_W       = 92;   // speed to the fourth
    localparam int GV2_W      = 68;   // gravity times speed squared
    localparam int WS_W       = 112;  // discriminant terms
    localparam int SQ_IN_W    = 104;  // square root radicand
    localparam int SQ_OUT_W   = 52;   // square root result
    localparam int NRM_W      = 56;   // normalized operand width
    localparam int NRM_CELLS  = 6;    // shifts by 32, 16, 8, 4, 2, 1
    localparam int CX_W       = 60;   // CORDIC x and y
    localparam int CZ_W       = 26;   // CORDIC angle, degrees * 65536
    localparam int ELEV_W     = 16;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Squared distance below which the target counts as too close (0.01 m)
    localparam logic [Q_W-1:0] NEAR_LIMIT_SQ = 66'd429497;

    // Largest magnitude of the output angle, Q8.8 degrees (90 degrees)
    localparam logic signed [CZ_W-1:0] ANGLE_MAX_Q8 = 26'sd23040;

    // Register reset values
    localparam logic [V_W-1:0] RST_LAUNCH_SPEED = 23'd1638400;
    localparam logic [G_W-1:0] RST_GRAVITY      = 22'd642908;
    localparam logic [P_W-1:0] RST_AIM_X        = 32'd1340211;
    localparam logic [P_W-1:0] RST_AIM_Y        = 32'hFFFF_E148;
    localparam logic [P_W-1:0] RST_AIM_Z        = 32'd88015;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAUNCH_SPEED = 3'd0,
        REG_GRAVITY      = 3'd1,
        REG_AIM_X        = 3'd2,
        REG_AIM_Y        = 3'd3,
        REG_AIM_Z        = 3'd4
    } cfg_reg_t;

    typedef enum logic [STAT_W-1:0] {
        ST_SOLVED      = 2'd0,
        ST_TOO_CLOSE   = 2'd1,
        ST_UNREACHABLE = 2'd2
    } status_t;

    // atan(2^-i) in degrees * 65536, rounded to nearest
    localparam logic signed [CZ_W-1:0] ATAN_DEG16 [0:CORDIC_MAX-1] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0,
        26'sd0,       26'sd0,       26'sd0,      26'sd0,
        26'sd0,       26'sd0,       26'sd0,      26'sd0
    };

endpackage

/* hw/rtl/plau_sqrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root cell
// One digit step of a restoring square root: settles one result bit and
// passes the shifted radicand, remainder and partial root to the next cell.
// ----------------------------------------------------------------------------
module plau_sqrt_cell (
    input  logic                             clk,
    input  logic                             en,
    input  logic [plau_pkg::SQ_IN_W-1:0]     rad_in,
    input  logic [plau_pkg::SQ_OUT_W+1:0]    rem_in,
    input  logic [plau_pkg::SQ_OUT_W-1:0]    root_in,
    output logic [plau_pkg::SQ_IN_W-1:0]     rad_out,
    output logic [plau_pkg::SQ_OUT_W+1:0]    rem_out,
    output logic [plau_pkg::SQ_OUT_W-1:0]    root_out
);

    localparam int IW = plau_pkg::SQ_IN_W;
    localparam int OW = plau_pkg::SQ_OUT_W;

    logic [OW+3:0] part;
    logic [OW+3:0] trial;
    logic [OW+3:0] diff;
    logic          fits;

    logic [IW-1:0] rad_reg;
    logic [OW+1:0] rem_reg;
    logic [OW-1:0] root_reg;

    always_comb
    begin
        part  = {rem_in, rad_in[IW-1:IW-2]};
        trial = {2'b00, root_in, 2'b01};
        fits  = (part >= trial);
        diff  = part - trial;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= {rad_in[IW-3:0], 2'b00};
            rem_reg  <= fits ? diff[OW+1:0] : part[OW+1:0];
            root_reg <= {root_in[OW-2:0], fits};
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

/* hw/rtl/plau_norm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Normalizer cell
// Shifts both arctangent operands left by SH when the larger of them still
// has its top SH bits clear.
// ----------------------------------------------------------------------------
module plau_norm_cell #(
    parameter int SH = 32
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic [plau_pkg::NRM_W-1:0]     ax_in,
    input  logic [plau_pkg::NRM_W-1:0]     ay_in,
    output logic [plau_pkg::NRM_W-1:0]     ax_out,
    output logic [plau_pkg::NRM_W-1:0]     ay_out
);

    localparam int NW = plau_pkg::NRM_W;

    logic [NW-1:0] both;
    logic          room;
    logic [NW-1:0] ax_reg;
    logic [NW-1:0] ay_reg;

    always_comb
    begin
        both = ax_in | ay_in;
        room = ((both >> (NW - SH)) == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= room ? (ax_in << SH) : ax_in;
            ay_reg <= room ? (ay_in << SH) : ay_in;
        end
    end

    assign ax_out = ax_reg;
    assign ay_out = ay_reg;

endmodule

/* hw/rtl/plau_cordic_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One rotation toward the x axis; the angle accumulator collects the
// table angle of this step.
// ----------------------------------------------------------------------------
module plau_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [plau_pkg::CX_W-1:0]    x_in,
    input  logic signed [plau_pkg::CX_W-1:0]    y_in,
    input  logic signed [plau_pkg::CZ_W-1:0]    z_in,
    output logic signed [plau_pkg::CX_W-1:0]    x_out,
    output logic signed [plau_pkg::CX_W-1:0]    y_out,
    output logic signed [plau_pkg::CZ_W-1:0]    z_out
);

    localparam logic signed [plau_pkg::CZ_W-1:0] ANG = plau_pkg::ATAN_DEG16[STAGE];

    logic signed [plau_pkg::CX_W-1:0] xs;
    logic signed [plau_pkg::CX_W-1:0] ys;
    logic signed [plau_pkg::CX_W-1:0] x_reg;
    logic signed [plau_pkg::CX_W-1:0] y_reg;
    logic signed [plau_pkg::CZ_W-1:0] z_reg;

    assign xs = x_in >>> STAGE;
    assign ys = y_in >>> STAGE;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!y_in[plau_pkg::CX_W-1])
            begin
                x_reg <= x_in + ys;
                y_reg <= y_in - xs;
                z_reg <= z_in + ANG;
            end
            else
            begin
                x_reg <= x_in - ys;
                y_reg <= y_in + xs;
                z_reg <= z_in - ANG;
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

/* hw/rtl/projectile_launch_angle_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projectile launch angle unit
// Finds the flatter drag-free launch elevation from a launcher position to a
// configured target, with launch speed and gravity set by registers.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Signals                      Content
//  s_axis   in   tvalid tready tdata[95:0]    start_x, start_y, start_z
//  m_axis   out  tvalid tready tdata tuser    elevation_deg, status
//  cfg      in   valid ready index data       speed, gravity, aim point x y z
//
// The unit takes one launcher position per cycle while m_axis is not stalled;
// new positions enter while earlier ones are still in the pipe.
// All stages advance together whenever the output register is empty or its
// transfer completes, so a stall on m_axis holds the whole pipe and drops
// s_axis_tready. Reset clears the valid flags and loads the register defaults.
// Derived register products are recomputed through their own registers after
// a configuration write.
//
// Datapath outline:
//   front  seven stages: differences, squares, partial products of the
//          discriminant, its sum and the unreachable check
//   sqrt   two 52-cell chains in lockstep: sqrt of the discriminant (R) and of
//          the squared horizontal distance (D)
//   angle  x = g*D, y = v^2 - R, normalized by a six-cell shift chain, then
//          CORDIC_STAGES vectoring cells and a rounding output stage
// ----------------------------------------------------------------------------
module projectile_launch_angle_unit #(
    parameter int CORDIC_STAGES = plau_pkg::CORDIC_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // [31:0] start_x, [63:32] start_y, [95:64] start_z

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] elevation_deg
    output logic [1:0]  m_axis_tuser,   // [1:0] status

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int NSQ = plau_pkg::SQ_OUT_W;
    localparam int NNM = plau_pkg::NRM_CELLS;
    localparam int NCS = CORDIC_STAGES;
    // Tail index 0 is the last front stage; NT is the stage before the output.
    localparam int NT  = NSQ + 1 + NNM + 1 + NCS;
    localparam int NFV = 6;

    localparam int D_W   = plau_pkg::D_W;
    localparam int Q_W   = plau_pkg::Q_W;
    localparam int WS_W  = plau_pkg::WS_W;
    localparam int SI_W  = plau_pkg::SQ_IN_W;
    localparam int SO_W  = plau_pkg::SQ_OUT_W;
    localparam int NW    = plau_pkg::NRM_W;
    localparam int CX_W  = plau_pkg::CX_W;
    localparam int CZ_W  = plau_pkg::CZ_W;

    // ------------------------------------------------------------------
    // Handshake: the pipe moves as one whenever the output can be loaded.
    // ------------------------------------------------------------------
    logic adv;
    logic in_acc;
    logic out_valid_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign in_acc        = s_axis_tvalid && adv;
    assign cfg_ready     = 1'b1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [plau_pkg::V_W-1:0] speed_reg;
    logic [plau_pkg::G_W-1:0] grav_reg;
    logic [plau_pkg::P_W-1:0] tx_reg;
    logic [plau_pkg::P_W-1:0] ty_reg;
    logic [plau_pkg::P_W-1:0] tz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= plau_pkg::RST_LAUNCH_SPEED;
            grav_reg  <= plau_pkg::RST_GRAVITY;
            tx_reg    <= plau_pkg::RST_AIM_X;
            ty_reg    <= plau_pkg::RST_AIM_Y;
            tz_reg    <= plau_pkg::RST_AIM_Z;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                plau_pkg::REG_LAUNCH_SPEED: speed_reg <= cfg_data[plau_pkg::V_W-1:0];
                plau_pkg::REG_GRAVITY:      grav_reg  <= cfg_data[plau_pkg::G_W-1:0];
                plau_pkg::REG_AIM_X:        tx_reg    <= cfg_data;
                plau_pkg::REG_AIM_Y:        ty_reg    <= cfg_data;
                plau_pkg::REG_AIM_Z:        tz_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Products of the registers alone. They are free running and are registered
    // in turn as the squares, their partial products and the summed v^4 and g*v^2.
    logic [plau_pkg::V2_W-1:0]  v2_reg;
    logic [plau_pkg::G2_W-1:0]  g2_reg;
    logic [63:0]                v4_ll_reg;
    logic [45:0]                v4_hl_reg;
    logic [27:0]                v4_hh_reg;
    logic [53:0]                gv_l_reg;
    logic [35:0]                gv_h_reg;
    logic [plau_pkg::V4_W-1:0]  v4_reg;
    logic [plau_pkg::GV2_W-1:0] gv2_reg;

    always_ff @(posedge clk)
    begin
        v2_reg    <= speed_reg * speed_reg;
        g2_reg    <= grav_reg * grav_reg;
        v4_ll_reg <= v2_reg[31:0] * v2_reg[31:0];
        v4_hl_reg <= v2_reg[45:32] * v2_reg[31:0];
        v4_hh_reg <= v2_reg[45:32] * v2_reg[45:32];
        gv_l_reg  <= grav_reg * v2_reg[31:0];
        gv_h_reg  <= grav_reg * v2_reg[45:32];
        v4_reg    <= plau_pkg::V4_W'(v4_ll_reg)
                   + (plau_pkg::V4_W'(v4_hl_reg) << 33)
                   + (plau_pkg::V4_W'(v4_hh_reg) << 64);
        gv2_reg   <= plau_pkg::GV2_W'(gv_l_reg) + (plau_pkg::GV2_W'(gv_h_reg) << 32);
    end

    // ------------------------------------------------------------------
    // Front stage 1: coordinate differences and their magnitudes
    // ------------------------------------------------------------------
    logic [D_W-1:0] dx_w, dy_w, dz_w;
    logic [D_W-1:0] adx_next, ady_next, adz_next;

    always_comb
    begin
        dx_w = {tx_reg[31], tx_reg} - {s_axis_tdata[31], s_axis_tdata[31:0]};
        dy_w = {ty_reg[31], ty_reg} - {s_axis_tdata[63], s_axis_tdata[63:32]};
        dz_w = {tz_reg[31], tz_reg} - {s_axis_tdata[95], s_axis_tdata[95:64]};
        adx_next = dx_w[D_W-1] ? (D_W'(0) - dx_w) : dx_w;
        ady_next = dy_w[D_W-1] ? (D_W'(0) - dy_w) : dy_w;
        adz_next = dz_w[D_W-1] ? (D_W'(0) - dz_w) : dz_w;
    end

    logic [D_W-1:0] s1_adx_reg, s1_ady_reg, s1_adz_reg;
    logic           s1_dzn_reg, s1_dzp_reg;

    // Stage 2: squares
    logic [Q_W-1:0] s2_sqx_reg, s2_sqy_reg;
    logic [D_W-1:0] s2_adz_reg;
    logic           s2_dzn_reg, s2_dzp_reg;

    // Stage 3: squared horizontal distance and the too-close check
    logic [Q_W-1:0] q_next;
    logic [Q_W-1:0] s3_q_reg;
    logic           s3_close_reg;
    logic [D_W-1:0] s3_adz_reg;
    logic           s3_dzn_reg, s3_dzp_reg;

    assign q_next = s2_sqx_reg + s2_sqy_reg;

    // Stage 4: partial products of g^2*Q and g*v^2*|dz|
    logic [63:0]    s4_n00_reg, s4_n10_reg;
    logic [43:0]    s4_n01_reg, s4_n11_reg;
    logic [33:0]    s4_n20_reg;
    logic [13:0]    s4_n21_reg;
    logic [63:0]    s4_c0_reg, s4_c1_reg;
    logic [35:0]    s4_c2_reg;
    logic           s4_a1_reg;
    logic [Q_W-1:0] s4_q_reg;
    logic           s4_close_reg, s4_dzn_reg, s4_dzp_reg;

    // Stage 5: sums of the partial products
    logic [WS_W-1:0] neg_next, c_next;
    logic [WS_W-1:0] s5_neg_reg, s5_c_reg;
    logic [Q_W-1:0]  s5_q_reg;
    logic            s5_close_reg, s5_dzn_reg, s5_dzp_reg;

    always_comb
    begin
        neg_next = WS_W'(s4_n00_reg)
                 + (WS_W'(s4_n01_reg) << 32)
                 + (WS_W'(s4_n10_reg) << 32)
                 + (WS_W'(s4_n11_reg) << 64)
                 + (WS_W'(s4_n20_reg) << 64)
                 + (WS_W'(s4_n21_reg) << 96);
        c_next   = (WS_W'(s4_c0_reg)
                 + (WS_W'(s4_c1_reg) << 32)
                 + (WS_W'(s4_c2_reg) << 64)
                 + (s4_a1_reg ? (WS_W'(gv2_reg) << 32) : WS_W'(0))) << 1;
    end

    // Stage 6: the height term joins the side that its sign selects
    logic [WS_W-1:0] s6_pos_reg, s6_neg_reg;
    logic [Q_W-1:0]  s6_q_reg;
    logic            s6_close_reg;

    // Stage 7: discriminant and the status of the item
    logic [WS_W-1:0] disc_w;
    logic            unreach_w;
    logic [1:0]      status_next;
    logic [SI_W-1:0] s7_rad_reg;
    logic [SI_W-1:0] s7_qrad_reg;

    always_comb
    begin
        disc_w    = s6_pos_reg - s6_neg_reg;
        unreach_w = (s6_pos_reg < s6_neg_reg);
        if (s6_close_reg)
        begin
            status_next = plau_pkg::ST_TOO_CLOSE;
        end
        else if (unreach_w)
        begin
            status_next = plau_pkg::ST_UNREACHABLE;
        end
        else
        begin
            status_next = plau_pkg::ST_SOLVED;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_adx_reg   <= adx_next;
            s1_ady_reg   <= ady_next;
            s1_adz_reg   <= adz_next;
            s1_dzn_reg   <= dz_w[D_W-1];
            s1_dzp_reg   <= !dz_w[D_W-1] && (dz_w != '0);

            s2_sqx_reg   <= s1_adx_reg * s1_adx_reg;
            s2_sqy_reg   <= s1_ady_reg * s1_ady_reg;
            s2_adz_reg   <= s1_adz_reg;
            s2_dzn_reg   <= s1_dzn_reg;
            s2_dzp_reg   <= s1_dzp_reg;

            s3_q_reg     <= q_next;
            s3_close_reg <= (q_next < plau_pkg::NEAR_LIMIT_SQ);
            s3_adz_reg   <= s2_adz_reg;
            s3_dzn_reg   <= s2_dzn_reg;
            s3_dzp_reg   <= s2_dzp_reg;

            s4_n00_reg   <= s3_q_reg[31:0]  * g2_reg[31:0];
            s4_n01_reg   <= s3_q_reg[31:0]  * g2_reg[43:32];
            s4_n10_reg   <= s3_q_reg[63:32] * g2_reg[31:0];
            s4_n11_reg   <= s3_q_reg[63:32] * g2_reg[43:32];
            s4_n20_reg   <= s3_q_reg[65:64] * g2_reg[31:0];
            s4_n21_reg   <= s3_q_reg[65:64] * g2_reg[43:32];
            s4_c0_reg    <= gv2_reg[31:0]  * s3_adz_reg[31:0];
            s4_c1_reg    <= gv2_reg[63:32] * s3_adz_reg[31:0];
            s4_c2_reg    <= gv2_reg[67:64] * s3_adz_reg[31:0];
            s4_a1_reg    <= s3_adz_reg[32];
            s4_q_reg     <= s3_q_reg;
            s4_close_reg <= s3_close_reg;
            s4_dzn_reg   <= s3_dzn_reg;
            s4_dzp_reg   <= s3_dzp_reg;

            s5_neg_reg   <= neg_next;
            s5_c_reg     <= c_next;
            s5_q_reg     <= s4_q_reg;
            s5_close_reg <= s4_close_reg;
            s5_dzn_reg   <= s4_dzn_reg;
            s5_dzp_reg   <= s4_dzp_reg;

            s6_pos_reg   <= WS_W'(v4_reg) + (s5_dzn_reg ? s5_c_reg : WS_W'(0));
            s6_neg_reg   <= s5_neg_reg + (s5_dzp_reg ? s5_c_reg : WS_W'(0));
            s6_q_reg     <= s5_q_reg;
            s6_close_reg <= s5_close_reg;

            // A negative discriminant feeds zero; its result is overridden.
            s7_rad_reg   <= unreach_w ? SI_W'(0) : disc_w[SI_W-1:0];
            s7_qrad_reg  <= SI_W'(s6_q_reg);
        end
    end

    // ------------------------------------------------------------------
    // Valid and status lines that travel beside the datapath
    // ------------------------------------------------------------------
    logic       fv_reg [1:NFV];
    logic       tv_reg [0:NT];
    logic [1:0] ts_reg [0:NT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= NFV; k++)
            begin
                fv_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= NT; k++)
            begin
                tv_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            fv_reg[1] <= in_acc;
            for (int k = 2; k <= NFV; k++)
            begin
                fv_reg[k] <= fv_reg[k-1];
            end
            tv_reg[0] <= fv_reg[NFV];
            for (int k = 1; k <= NT; k++)
            begin
                tv_reg[k] <= tv_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ts_reg[0] <= status_next;
            for (int k = 1; k <= NT; k++)
            begin
                ts_reg[k] <= ts_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Square root chains: R from the discriminant, D from Q, in lockstep
    // ------------------------------------------------------------------
    logic [SI_W-1:0] r_rad  [0:NSQ];
    logic [SO_W+1:0] r_rem  [0:NSQ];
    logic [SO_W-1:0] r_root [0:NSQ];
    logic [SI_W-1:0] d_rad  [0:NSQ];
    logic [SO_W+1:0] d_rem  [0:NSQ];
    logic [SO_W-1:0] d_root [0:NSQ];

    assign r_rad[0]  = s7_rad_reg;
    assign r_rem[0]  = '0;
    assign r_root[0] = '0;
    assign d_rad[0]  = s7_qrad_reg;
    assign d_rem[0]  = '0;
    assign d_root[0] = '0;

    for (genvar j = 0; j < NSQ; j++)
    begin : g_sqrt
        plau_sqrt_cell u_r_cell (
            .clk      (clk),
            .en       (adv),
            .rad_in   (r_rad[j]),
            .rem_in   (r_rem[j]),
            .root_in  (r_root[j]),
            .rad_out  (r_rad[j+1]),
            .rem_out  (r_rem[j+1]),
            .root_out (r_root[j+1])
        );
        plau_sqrt_cell u_d_cell (
            .clk      (clk),
            .en       (adv),
            .rad_in   (d_rad[j]),
            .rem_in   (d_rem[j]),
            .root_in  (d_root[j]),
            .rad_out  (d_rad[j+1]),
            .rem_out  (d_rem[j+1]),
            .root_out (d_root[j+1])
        );
    end

    // ------------------------------------------------------------------
    // Arctangent operands: x = g*D, y = v^2 - R as magnitude and sign
    // ------------------------------------------------------------------
    logic [54:0]   ax_prod;
    logic [53:0]   yd_w;
    logic [53:0]   ay_w;
    logic [NW-1:0] p1_ax_reg;
    logic [NW-1:0] p1_ay_reg;
    logic          yn_reg [0:NNM];

    always_comb
    begin
        ax_prod = grav_reg * d_root[NSQ][D_W-1:0];
        yd_w    = {8'b0, v2_reg} - {2'b0, r_root[NSQ]};
        ay_w    = yd_w[53] ? (54'd0 - yd_w) : yd_w;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_ax_reg <= NW'(ax_prod);
            p1_ay_reg <= NW'(ay_w);
            yn_reg[0] <= yd_w[53];
            for (int k = 1; k <= NNM; k++)
            begin
                yn_reg[k] <= yn_reg[k-1];
            end
        end
    end

    // Normalizer chain: the larger operand ends with its top bit at 2^55
    logic [NW-1:0] n_ax [0:NNM];
    logic [NW-1:0] n_ay [0:NNM];

    assign n_ax[0] = p1_ax_reg;
    assign n_ay[0] = p1_ay_reg;

    for (genvar n = 0; n < NNM; n++)
    begin : g_norm
        plau_norm_cell #(
            .SH (32 >> n)
        ) u_norm (
            .clk    (clk),
            .en     (adv),
            .ax_in  (n_ax[n]),
            .ay_in  (n_ay[n]),
            .ax_out (n_ax[n+1]),
            .ay_out (n_ay[n+1])
        );
    end

    // Signed CORDIC start values; both operands zero means zero gravity.
    logic signed [CX_W-1:0] p3_x_reg;
    logic signed [CX_W-1:0] p3_y_reg;
    logic                   zf_reg [0:NCS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_x_reg  <= CX_W'(n_ax[NNM]);
            p3_y_reg  <= yn_reg[NNM] ? (CX_W'(0) - CX_W'(n_ay[NNM])) : CX_W'(n_ay[NNM]);
            zf_reg[0] <= ((n_ax[NNM] | n_ay[NNM]) == '0);
            for (int k = 1; k <= NCS; k++)
            begin
                zf_reg[k] <= zf_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // CORDIC vectoring chain
    // ------------------------------------------------------------------
    logic signed [CX_W-1:0] cx [0:NCS];
    logic signed [CX_W-1:0] cy [0:NCS];
    logic signed [CZ_W-1:0] cz [0:NCS];

    assign cx[0] = p3_x_reg;
    assign cy[0] = p3_y_reg;
    assign cz[0] = '0;

    for (genvar i = 0; i < NCS; i++)
    begin : g_cordic
        plau_cordic_cell #(
            .STAGE (i)
        ) u_cordic (
            .clk   (clk),
            .en    (adv),
            .x_in  (cx[i]),
            .y_in  (cy[i]),
            .z_in  (cz[i]),
            .x_out (cx[i+1]),
            .y_out (cy[i+1]),
            .z_out (cz[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Output stage: round half up to Q8.8, clamp to +-90 degrees, and
    // force zero for the too-close, unreachable and zero-operand cases.
    // ------------------------------------------------------------------
    logic signed [CZ_W-1:0]  z_rnd;
    logic signed [CZ_W-1:0]  z_sat;
    logic [plau_pkg::ELEV_W-1:0] elev_next;
    logic [plau_pkg::ELEV_W-1:0] out_elev_reg;
    logic [1:0]                  out_stat_reg;

    always_comb
    begin
        z_rnd = (cz[NCS] + CZ_W'(128)) >>> 8;
        if (z_rnd > plau_pkg::ANGLE_MAX_Q8)
        begin
            z_sat = plau_pkg::ANGLE_MAX_Q8;
        end
        else if (z_rnd < -plau_pkg::ANGLE_MAX_Q8)
        begin
            z_sat = -plau_pkg::ANGLE_MAX_Q8;
        end
        else
        begin
            z_sat = z_rnd;
        end
        if (zf_reg[NCS] || (ts_reg[NT] != plau_pkg::ST_SOLVED))
        begin
            elev_next = '0;
        end
        else
        begin
            elev_next = z_sat[plau_pkg::ELEV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= tv_reg[NT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_elev_reg <= elev_next;
            out_stat_reg <= ts_reg[NT];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_elev_reg;
    assign m_axis_tuser  = out_stat_reg;

`ifndef SYNTHESIS
    // A result that is not solved carries a zero angle.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != plau_pkg::ST_SOLVED)) |-> (m_axis_tdata == '0))
        else $error("unsolved result with nonzero elevation");

    // The angle stays within the clamp limits.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata) <= 16'sd23040 &&
                           $signed(m_axis_tdata) >= -16'sd23040))
        else $error("elevation outside the clamp range");

    // A blocked output holds the whole pipe, so no new item may enter.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while the output is stalled");

    // Status codes above unreachable never appear.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == plau_pkg::ST_SOLVED ||
                           m_axis_tuser == plau_pkg::ST_TOO_CLOSE ||
                           m_axis_tuser == plau_pkg::ST_UNREACHABLE))
        else $error("undefined status code");
`endif

endmodule
